FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TMS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define TMS_ASSERT(label, prop, msg)
`define TMS_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

FILE: rtl/core/tms_pkg.sv
// ---------------------------------------------------------------------------
// tms_pkg
// Types and codes shared by the Turing machine step engine.
// ---------------------------------------------------------------------------
package tms_pkg;

    // Command codes carried in the input beat.
    localparam logic [2:0] CMD_CLEAR_RULES = 3'd0;
    localparam logic [2:0] CMD_APPEND_RULE = 3'd1;
    localparam logic [2:0] CMD_CLEAR_TAPE  = 3'd2;
    localparam logic [2:0] CMD_APPEND_CELL = 3'd3;
    localparam logic [2:0] CMD_START       = 3'd4;
    localparam logic [2:0] CMD_STEP        = 3'd5;

    // Run modes.
    localparam logic [2:0] MODE_RUN     = 3'd0;
    localparam logic [2:0] MODE_ACCEPT  = 3'd1;
    localparam logic [2:0] MODE_REJECT  = 3'd2;
    localparam logic [2:0] MODE_NO_RULE = 3'd3;
    localparam logic [2:0] MODE_FULL    = 3'd4;

    // Head moves.
    localparam logic [1:0] MOVE_LEFT  = 2'd1;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_ACCEPT = 3'd1;
    localparam logic [2:0] REG_REJECT = 3'd2;
    localparam logic [2:0] REG_WILD   = 3'd3;
    localparam logic [2:0] REG_EMPTY  = 3'd4;

    localparam int RULE_W = 34;

    typedef struct packed {
        logic [7:0] state;
        logic [7:0] rd;
        logic [7:0] wr;
        logic [1:0] mv;
        logic [7:0] next;
    } rule_t;

endpackage

FILE: rtl/core/tms_ram.sv
// ---------------------------------------------------------------------------
// tms_ram
// Single-write, single-read synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/turing_machine_step.sv
// Table and tape commands go from the input beat through ST_FIN and ST_RDOUT to the
// output beat. A step reads the head cell, then scans the rules with one rule memory
// read per cycle; it adds a blank cell at the right end when needed, or, when the head
// leaves the left end, moves every cell up one place and puts a blank in cell 0.
// One item is in work at a time. Reset is asynchronous and clears all control
// state; the memories are not cleared, only the counts are.
`include "assert_macros.svh"
module turing_machine_step #(
    parameter int TABLE_DEPTH = 64,
    parameter int TAPE_DEPTH  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rule_state[7:0], rule_read[15:8], rule_write[23:16], rule_move[25:24],
    // rule_next[33:26], cell_symbol[41:34]
    input  logic [47:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // took_effect[0], run_mode[3:1], machine_state[11:4], head_position[21:12],
    // tape_used[32:22], head_cell[40:33]
    output logic [47:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import tms_pkg::*;

    localparam int RAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int HW  = $clog2(TAPE_DEPTH);
    localparam int LW  = $clog2(TAPE_DEPTH + 1);
    localparam int XW  = LW + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RDSYM    = 4'd1;
    localparam logic [3:0] ST_SCAN     = 4'd2;
    localparam logic [3:0] ST_APPLY    = 4'd3;
    localparam logic [3:0] ST_SHIFT_RD = 4'd4;
    localparam logic [3:0] ST_SHIFT_WR = 4'd5;
    localparam logic [3:0] ST_GROW     = 4'd6;
    localparam logic [3:0] ST_FIN      = 4'd7;
    localparam logic [3:0] ST_RDOUT    = 4'd8;

    // Control and architectural registers.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] len_reg, len_next;
    logic [HW-1:0] head_reg, head_next;
    logic [7:0]    pstate_reg, pstate_next;
    logic [2:0]    mode_reg, mode_next;
    logic          ok_reg, ok_next;
    logic [7:0]    sym_reg, sym_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic          fb_reg, fb_next;
    rule_t         hit_reg, hit_next;
    logic [LW-1:0] shift_reg, shift_next;
    logic [7:0]    start_reg, accept_reg, reject_reg, wild_reg, empty_reg;
    logic          out_valid_reg;
    logic [47:0]   out_data_reg;

    // Memory ports.
    logic              rule_we, rule_re;
    logic [RAW-1:0]    rule_waddr, rule_raddr;
    rule_t             rule_wdata, rule_rdata;
    logic [RULE_W-1:0] rule_rbits;
    logic              tape_we, tape_re;
    logic [HW-1:0]     tape_waddr, tape_raddr;
    logic [7:0]        tape_wdata, tape_rdata;

    // Input fields.
    logic [2:0] in_cmd;
    rule_t      in_rule;
    logic [7:0] in_cell;

    // Step helpers.
    logic          head_on, halted, left_grow, right_grow, tape_full;
    logic [XW-1:0] newpos, len_x;
    logic [7:0]    cell_now;
    logic          load_out;
    logic [HW+9:0] head_ext;
    logic [LW+10:0] len_ext;

    assign in_cmd        = s_tuser;
    assign in_rule.state = s_tdata[7:0];
    assign in_rule.rd    = s_tdata[15:8];
    assign in_rule.wr    = s_tdata[23:16];
    assign in_rule.mv    = s_tdata[25:24];
    assign in_rule.next  = s_tdata[33:26];
    assign in_cell       = s_tdata[41:34];

    tms_ram #(.WIDTH(RULE_W), .DEPTH(TABLE_DEPTH), .AW(RAW)) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (rule_waddr),
        .wdata (rule_wdata),
        .re    (rule_re),
        .raddr (rule_raddr),
        .rdata (rule_rbits)
    );
    assign rule_rdata = rule_t'(rule_rbits);

    tms_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH), .AW(HW)) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    // Shared status terms.
    assign head_on  = LW'(head_reg) < len_reg;
    assign halted   = (mode_reg != MODE_RUN) || (pstate_reg == accept_reg)
                      || (pstate_reg == reject_reg);
    assign cell_now = head_on ? tape_rdata : empty_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_RDOUT) && (!out_valid_reg || m_tready);
    assign len_x    = XW'(len_reg);

    // Head move decision for the selected rule.
    always_comb
    begin
        left_grow = (hit_reg.mv == MOVE_LEFT) && (head_reg == '0);
        newpos    = XW'(head_reg);
        if ((hit_reg.mv == MOVE_LEFT) && (head_reg != '0))
        begin
            newpos = XW'(head_reg) - XW'(1);
        end
        else if (hit_reg.mv == MOVE_RIGHT)
        begin
            newpos = XW'(head_reg) + XW'(1);
        end
        right_grow = !left_grow && (newpos >= len_x);
        tape_full  = (left_grow && (len_x == XW'(TAPE_DEPTH)))
                     || (right_grow && ((len_x == XW'(TAPE_DEPTH))
                                        || (newpos >= XW'(TAPE_DEPTH))));
    end

    // Main sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        head_next   = head_reg;
        pstate_next = pstate_reg;
        mode_next   = mode_reg;
        ok_next     = ok_reg;
        sym_next    = sym_reg;
        issue_next  = issue_reg;
        pend_next   = pend_reg;
        fb_next     = fb_reg;
        hit_next    = hit_reg;
        shift_next  = shift_reg;
        rule_we     = 1'b0;
        rule_waddr  = count_reg[RAW-1:0];
        rule_wdata  = in_rule;
        rule_re     = 1'b0;
        rule_raddr  = issue_reg[RAW-1:0];
        tape_we     = 1'b0;
        tape_waddr  = head_reg;
        tape_wdata  = in_cell;
        tape_re     = 1'b0;
        tape_raddr  = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ok_next    = 1'b0;
                    state_next = ST_FIN;
                    case (in_cmd)
                        CMD_CLEAR_RULES:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        CMD_APPEND_RULE:
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                rule_we    = 1'b1;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_FULL;
                            end
                        end
                        CMD_CLEAR_TAPE:
                        begin
                            len_next = '0;
                            ok_next  = 1'b1;
                        end
                        CMD_APPEND_CELL:
                        begin
                            if (len_reg < LW'(TAPE_DEPTH))
                            begin
                                tape_we    = 1'b1;
                                tape_waddr = len_reg[HW-1:0];
                                len_next   = len_reg + LW'(1);
                                ok_next    = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_FULL;
                            end
                        end
                        CMD_START:
                        begin
                            head_next   = '0;
                            pstate_next = start_reg;
                            ok_next     = 1'b1;
                            if (start_reg == accept_reg)
                            begin
                                mode_next = MODE_ACCEPT;
                            end
                            else if (start_reg == reject_reg)
                            begin
                                mode_next = MODE_REJECT;
                            end
                            else
                            begin
                                mode_next = MODE_RUN;
                            end
                        end
                        CMD_STEP:
                        begin
                            if (!halted)
                            begin
                                tape_re    = head_on;
                                state_next = ST_RDSYM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDSYM:
            begin
                sym_next   = cell_now;
                issue_next = '0;
                pend_next  = 1'b0;
                fb_next    = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Issue one rule read per cycle, evaluate the previous one.
                pend_next = 1'b0;
                if (issue_reg < count_reg)
                begin
                    rule_re    = 1'b1;
                    issue_next = issue_reg + CW'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg && (rule_rdata.state == pstate_reg))
                begin
                    if (rule_rdata.rd == sym_reg)
                    begin
                        hit_next   = rule_rdata;
                        state_next = ST_APPLY;
                    end
                    else if (!fb_reg && ((sym_reg == wild_reg) || (rule_rdata.rd == wild_reg)))
                    begin
                        hit_next = rule_rdata;
                        fb_next  = 1'b1;
                    end
                end
                if (!pend_reg && (issue_reg >= count_reg))
                begin
                    if (fb_reg)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        mode_next  = MODE_NO_RULE;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_APPLY:
            begin
                if (tape_full)
                begin
                    mode_next  = MODE_FULL;
                    state_next = ST_FIN;
                end
                else
                begin
                    tape_we     = (hit_reg.wr != wild_reg) && head_on;
                    tape_wdata  = hit_reg.wr;
                    head_next   = left_grow ? '0 : newpos[HW-1:0];
                    pstate_next = hit_reg.next;
                    ok_next     = 1'b1;
                    if (hit_reg.next == accept_reg)
                    begin
                        mode_next = MODE_ACCEPT;
                    end
                    else if (hit_reg.next == reject_reg)
                    begin
                        mode_next = MODE_REJECT;
                    end
                    shift_next = len_reg;
                    if (left_grow)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else if (right_grow)
                    begin
                        state_next = ST_GROW;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                // Move cells up one place, from the top down.
                if (shift_reg == '0)
                begin
                    tape_we    = 1'b1;
                    tape_waddr = '0;
                    tape_wdata = empty_reg;
                    len_next   = len_reg + LW'(1);
                    state_next = ST_FIN;
                end
                else
                begin
                    tape_re    = 1'b1;
                    tape_raddr = HW'(shift_reg - LW'(1));
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                tape_we    = 1'b1;
                tape_waddr = shift_reg[HW-1:0];
                tape_wdata = tape_rdata;
                shift_next = shift_reg - LW'(1);
                state_next = ST_SHIFT_RD;
            end
            ST_GROW:
            begin
                tape_we    = 1'b1;
                tape_waddr = len_reg[HW-1:0];
                tape_wdata = empty_reg;
                len_next   = len_reg + LW'(1);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                tape_re    = head_on;
                state_next = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            len_reg    <= '0;
            head_reg   <= '0;
            pstate_reg <= '0;
            mode_reg   <= MODE_RUN;
            ok_reg     <= 1'b0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            fb_reg     <= 1'b0;
            shift_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            head_reg   <= head_next;
            pstate_reg <= pstate_next;
            mode_reg   <= mode_next;
            ok_reg     <= ok_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            fb_reg     <= fb_next;
            shift_reg  <= shift_next;
        end
    end

    // Payload registers of the step.
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        hit_reg <= hit_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 8'd0;
            accept_reg <= 8'd1;
            reject_reg <= 8'd2;
            wild_reg   <= 8'd42;
            empty_reg  <= 8'd95;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_START:  start_reg  <= cfg_wdata;
                REG_ACCEPT: accept_reg <= cfg_wdata;
                REG_REJECT: reject_reg <= cfg_wdata;
                REG_WILD:   wild_reg   <= cfg_wdata;
                REG_EMPTY:  empty_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Output register.
    assign head_ext = (HW + 10)'(head_reg);
    assign len_ext  = (LW + 11)'(len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {7'd0, cell_now, len_ext[10:0], head_ext[9:0],
                             pstate_reg, mode_reg, ok_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TMS_ASSERT(a_len_bound, len_reg <= LW'(TAPE_DEPTH), "tape length past depth")
    `TMS_ASSERT(a_count_bound, count_reg <= CW'(TABLE_DEPTH), "rule count past depth")
    `TMS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, state_reg != ST_IDLE, "idle after beat")
    `TMS_ASSERT_NEXT(a_out_load, load_out, m_tvalid, "result beat lost")

endmodule
